[sv/itoa_pkg.sv]
// Package for the integer to ASCII radix converter.
// Holds the character constants, radix limits, state type and helper functions.
// Depends on nothing.
package itoa_pkg;

    localparam int VALUE_WIDTH_DEFAULT = 32;
    localparam int RADIX_W             = 6;
    localparam int CHAR_W              = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN     = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET   = 6'd10;
    localparam logic [RADIX_W-1:0] DECIMAL_RADIX = 6'd10;
    localparam logic [RADIX_W-1:0] LARGEST_NUMERAL = 6'd9;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_Z     = 7'h7a;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_READ,
        ST_LOAD
    } state_t;

    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] res;
        if (d > LARGEST_NUMERAL) begin
            res = CHAR_A + CHAR_W'(d - DECIMAL_RADIX);
        end else begin
            res = CHAR_ZERO + CHAR_W'(d);
        end
        return res;
    endfunction

endpackage

[sv/int_to_ascii_radix.sv]
// Top level of the integer to ASCII radix converter.
// Serial restoring divider, digit memory and character output register.
// Depends on itoa_pkg.
//
// Each accepted value is divided by the radix one quotient bit per cycle in the
// shared bit-serial divider; the digits are then played out of a small digit
// memory in reverse order, each character by a memory read, then an output
// register load, after a leading minus sign for a negative decimal value. A new
// value is accepted once the previous run is fully handed to the output register.
module int_to_ascii_radix
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [RADIX_W-1:0]            cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [VALUE_WIDTH-1:0] s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [CHAR_W-1:0]             m_character,
    output logic                          m_last
);

    localparam int CNT_W = $clog2(VALUE_WIDTH);
    localparam int IDX_W = $clog2(VALUE_WIDTH);
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(VALUE_WIDTH - 1);

    state_t state_reg, state_next;

    logic [RADIX_W-1:0]     radix_reg;
    logic [RADIX_W-1:0]     base_reg;
    logic                   neg_reg;
    logic [VALUE_WIDTH-1:0] quo_reg;
    logic [RADIX_W-1:0]     rem_reg;
    logic [CNT_W-1:0]       bit_cnt_reg;
    logic [IDX_W-1:0]       wr_idx_reg;
    logic [IDX_W-1:0]       rd_idx_reg;
    logic [RADIX_W-1:0]     rd_data_reg;
    logic [RADIX_W-1:0]     digit_mem [VALUE_WIDTH];

    logic                   m_valid_reg;
    logic [CHAR_W-1:0]      m_character_reg;
    logic                   m_last_reg;

    logic                   accept;
    logic                   out_free;
    logic                   in_neg;
    logic [VALUE_WIDTH-1:0] in_mag;
    logic [RADIX_W:0]       trial;
    logic                   qbit;
    logic [RADIX_W-1:0]     rem_next;
    logic [VALUE_WIDTH-1:0] quo_next;
    logic                   digit_done;
    logic                   conv_done;
    logic                   load_sign;
    logic                   load_digit;

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign out_free    = !m_valid_reg || m_ready;
    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;

    assign in_neg = (eff_radix(radix_reg) == DECIMAL_RADIX) && s_value[VALUE_WIDTH-1];
    assign in_mag = in_neg ? (~s_value + VALUE_WIDTH'(1)) : s_value;

    // One restoring division step per cycle.
    assign trial    = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign qbit     = (trial >= {1'b0, base_reg});
    assign rem_next = qbit ? RADIX_W'(trial - {1'b0, base_reg}) : trial[RADIX_W-1:0];
    assign quo_next = {quo_reg[VALUE_WIDTH-2:0], qbit};

    assign digit_done = (state_reg == ST_DIV) && (bit_cnt_reg == '0);
    assign conv_done  = digit_done && (quo_next == '0);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (conv_done) begin
                    state_next = neg_reg ? ST_SIGN : ST_READ;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    state_next = (rd_idx_reg == '0) ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        load_sign  = 1'b0;
        load_digit = 1'b0;
        unique case (state_reg)
            ST_SIGN: load_sign  = out_free;
            ST_LOAD: load_digit = out_free;
            default: begin
                load_sign  = 1'b0;
                load_digit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            radix_reg   <= RADIX_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                radix_reg <= cfg_wdata;
            end
            if (load_sign || load_digit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            base_reg    <= eff_radix(radix_reg);
            neg_reg     <= in_neg;
            quo_reg     <= in_mag;
            rem_reg     <= '0;
            bit_cnt_reg <= CNT_TOP;
            wr_idx_reg  <= '0;
        end else if (state_reg == ST_DIV) begin
            quo_reg <= quo_next;
            if (digit_done) begin
                rem_reg     <= '0;
                bit_cnt_reg <= CNT_TOP;
                wr_idx_reg  <= wr_idx_reg + IDX_W'(1);
                rd_idx_reg  <= wr_idx_reg;
            end else begin
                rem_reg     <= rem_next;
                bit_cnt_reg <= bit_cnt_reg - CNT_W'(1);
            end
        end else if (load_digit) begin
            rd_idx_reg <= rd_idx_reg - IDX_W'(1);
        end

        if (load_sign) begin
            m_character_reg <= CHAR_MINUS;
            m_last_reg      <= 1'b0;
        end else if (load_digit) begin
            m_character_reg <= digit_char(rd_data_reg);
            m_last_reg      <= (rd_idx_reg == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (digit_done) begin
            digit_mem[wr_idx_reg] <= rem_next;
        end
        rd_data_reg <= digit_mem[rd_idx_reg];
    end

`ifndef NO_ASSERTIONS
    a_rem_below_base: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < base_reg))
        else $error("remainder not below radix during division");

    a_accept_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == ST_DIV))
        else $error("accepted value did not start division");

    a_digit_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD) |-> (rd_data_reg < base_reg))
        else $error("stored digit not below radix");

    a_char_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_character_reg >= CHAR_ZERO && m_character_reg <= CHAR_NINE) ||
                         (m_character_reg >= CHAR_A && m_character_reg <= CHAR_Z) ||
                         (m_character_reg == CHAR_MINUS)))
        else $error("illegal output character");

    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_character_reg == CHAR_MINUS) |-> !m_last_reg)
        else $error("minus sign flagged as last character");
`endif

endmodule

[test/tb.sv]
// Testbench for int_to_ascii_radix: sends integers, predicts the character runs in the
// configured radix and checks every output transaction against the prediction.
// Depends on itoa_pkg and the int_to_ascii_radix RTL.
module tb
    import itoa_pkg::*;
();

    localparam int VW = VALUE_WIDTH_DEFAULT;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } text_char_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              cfg_we;
    logic [RADIX_W-1:0] cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    logic [VW-1:0]     s_value;
    logic              m_valid;
    logic              m_ready;
    logic [CHAR_W-1:0] m_character;
    logic              m_last;

    text_char_t        expected_chars[$];
    logic [RADIX_W-1:0] radix_setting;
    int                error_count;
    int                sink_hold_cycles;
    bit                src_steady;
    bit                sink_steady;

    int_to_ascii_radix dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    always #4 aclk = ~aclk;

    function automatic logic [RADIX_W-1:0] effective_base(input logic [RADIX_W-1:0] r);
        if (r < RADIX_MIN) begin
            return RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            return RADIX_MAX;
        end
        return r;
    endfunction

    function automatic int pick_gap(input bit steady);
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 50) begin
            return 0;
        end else if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Pushes the characters of one value, most significant first, onto the expected queue.
    function automatic void predict_text(input logic [VW-1:0] value);
        logic [RADIX_W-1:0] base;
        logic [VW-1:0]      magnitude;
        logic [RADIX_W-1:0] digit;
        logic [CHAR_W-1:0]  chars[$];
        bit                 negative;
        text_char_t         entry;
        base = effective_base(radix_setting);
        negative = (base == DECIMAL_RADIX) && value[VW-1];
        magnitude = negative ? -value : value;
        if (magnitude == '0) begin
            chars.push_front(CHAR_ZERO);
        end
        while (magnitude != '0) begin
            digit = RADIX_W'(magnitude % base);
            if (digit > LARGEST_NUMERAL) begin
                chars.push_front(CHAR_A + CHAR_W'(digit - DECIMAL_RADIX));
            end else begin
                chars.push_front(CHAR_ZERO + CHAR_W'(digit));
            end
            magnitude = magnitude / base;
        end
        if (negative) begin
            chars.push_front(CHAR_MINUS);
        end
        foreach (chars[i]) begin
            entry.code = chars[i];
            entry.last = (i == chars.size() - 1);
            expected_chars.push_back(entry);
        end
    endfunction

    function automatic logic [VW-1:0] random_value();
        longint unsigned power;
        logic [RADIX_W-1:0] base;
        int shape;
        shape = $urandom_range(0, 9);
        base = effective_base(radix_setting);
        case (shape)
            0, 1, 2, 3: begin
                return $urandom;
            end
            4: begin
                return $urandom_range(0, 1000);
            end
            5: begin
                return -VW'($urandom_range(1, 1000));
            end
            6: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return {1'b1, {(VW-1){1'b0}}};
                    default: return {1'b0, {(VW-1){1'b1}}};
                endcase
            end
            7: begin
                return VW'(1) << $urandom_range(0, VW - 1);
            end
            default: begin
                power = 1;
                repeat ($urandom_range(1, VW - 1)) begin
                    if (power * base <= 64'hFFFF_FFFF) begin
                        power = power * base;
                    end
                end
                return $urandom_range(0, 1) ? VW'(power) : VW'(power - 1);
            end
        endcase
    endfunction

    // Offers one value after a random gap and holds it until the transaction completes.
    task automatic send_value(input logic [VW-1:0] value);
        int gap;
        gap = pick_gap(src_steady);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        predict_text(value);
    endtask

    task automatic wait_for_drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_chars.size() != 0);
        @(posedge aclk);
    endtask

    task automatic set_radix(input logic [RADIX_W-1:0] r);
        wait_for_drain();
        cfg_we <= 1'b1;
        cfg_wdata <= r;
        radix_setting = r;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic test_decimal_after_reset();
        send_value(VW'(0));
        send_value(VW'(1));
        send_value('1);
        send_value({1'b0, {(VW-1){1'b1}}});
        send_value({1'b1, {(VW-1){1'b0}}});
        send_value(VW'(10));
        send_value(-VW'(10));
        send_value(VW'(123456789));
    endtask

    task automatic test_radix_extremes();
        set_radix(RADIX_MIN);
        send_value('1);
        send_value({1'b1, {(VW-1){1'b0}}});
        send_value(32'h5555_5555);
        set_radix(RADIX_MAX);
        send_value(VW'(35));
        send_value('1);
        set_radix(6'd0);
        send_value(VW'(5));
        set_radix(6'd1);
        send_value('1);
        set_radix(6'd37);
        send_value(VW'(36));
        set_radix(6'd63);
        send_value({1'b0, {(VW-1){1'b1}}});
        set_radix(6'd16);
        send_value(32'hDEAD_BEEF);
        set_radix(6'd9);
        send_value({1'b1, {(VW-1){1'b0}}});
    endtask

    task automatic test_random_values();
        logic [RADIX_W-1:0] r;
        for (int phase = 0; phase < 10; phase++) begin
            if (phase == 0) begin
                r = RADIX_MIN;
            end else if (phase == 1) begin
                r = RADIX_MAX;
            end else if ($urandom_range(0, 99) < 80) begin
                r = $urandom_range(RADIX_MIN, RADIX_MAX);
            end else begin
                r = $urandom_range(0, 63);
            end
            set_radix(r);
            src_steady = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            repeat (20) send_value(random_value());
        end
        src_steady = 1'b0;
        sink_steady = 1'b0;
    endtask

    // The receiver stalls for a long stretch while values keep coming, so the input backs up.
    task automatic test_output_backpressure();
        set_radix(DECIMAL_RADIX);
        sink_hold_cycles = 400;
        src_steady = 1'b1;
        repeat (8) send_value(random_value());
        src_steady = 1'b0;
        wait_for_drain();
    endtask

    initial begin : sink_proc
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (sink_hold_cycles > 0) begin
                m_ready <= 1'b0;
                sink_hold_cycles--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                stall_left = pick_gap(sink_steady);
            end
        end
    end

    always @(posedge aclk) begin : check_chars
        text_char_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                error_count++;
                if (error_count <= 10) begin
                    $display("Unexpected character %h last %b", m_character, m_last);
                end
            end else begin
                want = expected_chars.pop_front();
                if (m_character !== want.code || m_last !== want.last) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("Mismatch: expected character %h last %b, got %h last %b",
                                 want.code, want.last, m_character, m_last);
                    end
                end
            end
        end
    end

    initial begin
        #32_000_000;
        $display("int_to_ascii_radix test failed");
        $finish;
    end

    initial begin
        error_count = 0;
        sink_hold_cycles = 0;
        src_steady = 1'b0;
        sink_steady = 1'b0;
        radix_setting = RADIX_RESET;
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_value <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_decimal_after_reset();
        test_radix_extremes();
        test_output_backpressure();
        test_random_values();

        wait_for_drain();
        repeat (50) @(posedge aclk);
        if (expected_chars.size() != 0) begin
            error_count++;
        end
        if (error_count == 0) begin
            $display("int_to_ascii_radix test passed");
        end else begin
            $display("int_to_ascii_radix test failed");
        end
        $finish;
    end
endmodule

[filelist.f]
sv/itoa_pkg.sv
sv/int_to_ascii_radix.sv
test/tb.sv
